FILE: hdl/lspf_pkg.sv
// ----------------------------------------------------------------------------
// lspf_pkg
// Shared types and constants of the line-sensor position filter: payload
// structs, configuration register map, back-end sequencer states.
// ----------------------------------------------------------------------------
package lspf_pkg;

  // Input item; pins are raw levels
  typedef struct packed {
    logic mode;
    logic pin_far_left;
    logic pin_near_left;
    logic pin_near_right;
    logic pin_far_right;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [16:0]        level_far_left;
    logic [16:0]        level_near_left;
    logic [16:0]        level_near_right;
    logic [16:0]        level_far_right;
    logic [3:0]         on_line_bits;
    logic signed [15:0] filtered_error;
    logic               line_lost;
  } out_item_t;

  // Classified item; sample bit 3 is far left, bit 0 far right
  typedef struct packed {
    logic       mode;
    logic [3:0] sample;
  } task_t;

  // Head of the queue between front and back
  typedef struct packed {
    logic  valid;
    task_t data;
  } queue_head_t;

  // Configuration; weight lane 3 is far left, lane 0 far right
  typedef struct packed {
    logic             active_high;
    logic [15:0]      level_alpha;
    logic [15:0]      error_alpha;
    logic [3:0][15:0] weight;
  } cfg_t;

  typedef enum logic [2:0] {
    CFG_ACTIVE_HIGH       = 3'd0,
    CFG_LEVEL_ALPHA       = 3'd1,
    CFG_ERROR_ALPHA       = 3'd2,
    CFG_WEIGHT_FAR_LEFT   = 3'd3,
    CFG_WEIGHT_NEAR_LEFT  = 3'd4,
    CFG_WEIGHT_NEAR_RIGHT = 3'd5,
    CFG_WEIGHT_FAR_RIGHT  = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LEVEL,
    BK_SUM,
    BK_DIV,
    BK_ERR,
    BK_FIN
  } back_state_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned QueueDepth = 2;

  // Register reset values
  localparam logic        RST_ACTIVE_HIGH = 1'b1;
  localparam logic [15:0] RST_ALPHA = 16'd32768;
  localparam logic [15:0] RST_W_FAR_LEFT = 16'hFD00;   // -3.0
  localparam logic [15:0] RST_W_NEAR_LEFT = 16'hFF00;  // -1.0
  localparam logic [15:0] RST_W_NEAR_RIGHT = 16'h0100; // +1.0
  localparam logic [15:0] RST_W_FAR_RIGHT = 16'h0300;  // +3.0

  // Error reported when no sensor is on: 99.0 in Q8.8
  localparam logic signed [15:0] LOST_ERROR = 16'sd25344;

  // ceil(2^17 / 3); exact for magnitudes below 2^17
  localparam logic [15:0] DIV3_RECIP = 16'd43691;
  localparam int unsigned Div3Shift = 17;

endpackage

FILE: hdl/lspf_front.sv
// ----------------------------------------------------------------------------
// lspf_front
// Input side: maps the raw pins to on-line samples by the active level and
// holds the classified items in a short queue for the back end.
// ----------------------------------------------------------------------------
module lspf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 active_high_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lspf_pkg::in_item_t   in_item_i,
  input  logic                 pop_i,
  output lspf_pkg::queue_head_t head_o
);

  localparam int unsigned PtrW = $clog2(lspf_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(lspf_pkg::QueueDepth + 1);

  lspf_pkg::task_t slot_q [lspf_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  lspf_pkg::task_t cls;
  logic            push;

  // Classify: a pin is on line when it matches the active level
  always_comb begin
    cls.mode      = in_item_i.mode;
    cls.sample[3] = (in_item_i.pin_far_left == active_high_i);
    cls.sample[2] = (in_item_i.pin_near_left == active_high_i);
    cls.sample[1] = (in_item_i.pin_near_right == active_high_i);
    cls.sample[0] = (in_item_i.pin_far_right == active_high_i);
  end

  assign in_ready_o = (cnt_q != CntW'(lspf_pkg::QueueDepth));
  assign push       = in_valid_i && in_ready_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(lspf_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(lspf_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the classified item on transfer
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = slot_q[rd_ptr_q];

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue popped while empty");

endmodule

FILE: hdl/lspf_back.sv
// ----------------------------------------------------------------------------
// lspf_back
// Execution side: a five-step sequencer that runs the level filters, the
// threshold and weight sum, the averaging and the error filter, then loads
// the output register.
// ----------------------------------------------------------------------------
module lspf_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lspf_pkg::cfg_t        cfg_i,
  input  lspf_pkg::queue_head_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lspf_pkg::out_item_t   out_item_o
);

  localparam int unsigned LW = FRAC_BITS + 1;
  localparam logic [LW-1:0] LVL_ONE = LW'(1) << FRAC_BITS;
  localparam logic [LW-1:0] LVL_HALF = LW'(1) << (FRAC_BITS - 1);

  lspf_pkg::back_state_e state_q, state_d;
  lspf_pkg::task_t       task_q;
  logic                  primed_q;
  logic [3:0][LW-1:0]    lvl_q;
  logic signed [15:0]    err_q;
  logic [3:0]            on_q;
  logic signed [17:0]    sum_q;
  logic [2:0]            cnt_q;
  logic [17:0]           mag_q;
  logic                  neg_q;
  logic [33:0]           div3_q;
  logic signed [33:0]    eprod_q;
  logic                  out_valid_q;
  lspf_pkg::out_item_t   out_q;

  logic [3:0][LW-1:0]    lvl_tgt;
  logic [3:0][LW-1:0]    lvl_next;
  logic [3:0]            on_now;
  logic signed [17:0]    sum_now;
  logic [2:0]            cnt_now;
  logic [17:0]           mag_now;
  logic [17:0]           qmag;
  logic signed [17:0]    qsig;
  logic signed [15:0]    err_tgt;
  logic signed [16:0]    ediff;
  logic signed [33:0]    eprod_now;
  logic signed [18:0]    esum;
  logic signed [15:0]    esat;
  logic signed [15:0]    err_new;
  logic                  out_free;
  logic                  fire;

  // Level filters: prev + floor(alpha * (target - prev) / 2^16)
  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic signed [LW:0]    diff;
    logic signed [LW+17:0] prod;
    assign lvl_tgt[k]  = task_q.sample[k] ? LVL_ONE : '0;
    assign diff        = $signed({1'b0, lvl_tgt[k]}) - $signed({1'b0, lvl_q[k]});
    assign prod        = $signed({1'b0, cfg_i.level_alpha}) * diff;
    assign lvl_next[k] = lvl_q[k] + prod[LW+15:16];
    assign on_now[k]   = (lvl_q[k] > LVL_HALF);
  end

  // Threshold and weight sum
  always_comb begin
    sum_now = '0;
    cnt_now = '0;
    for (int k = 0; k < 4; k++) begin
      if (on_now[k]) begin
        sum_now = sum_now + 18'($signed(cfg_i.weight[k]));
        cnt_now = cnt_now + 3'd1;
      end
    end
  end

  assign mag_now = sum_q[17] ? 18'(-sum_q) : sum_q;

  // Average truncated toward zero, then error difference and product
  always_comb begin
    case (cnt_q)
      3'd1:    qmag = mag_q;
      3'd2:    qmag = mag_q >> 1;
      3'd3:    qmag = {1'b0, div3_q[33:lspf_pkg::Div3Shift]};
      3'd4:    qmag = mag_q >> 2;
      default: qmag = mag_q;
    endcase
    qsig      = neg_q ? -$signed(qmag) : $signed(qmag);
    err_tgt   = (cnt_q == '0) ? lspf_pkg::LOST_ERROR : qsig[15:0];
    ediff     = $signed({err_tgt[15], err_tgt}) - $signed({err_q[15], err_q});
    eprod_now = $signed({1'b0, cfg_i.error_alpha}) * ediff;
  end

  // Add the floored step and saturate to 16 bits
  always_comb begin
    esum = $signed({{3{err_q[15]}}, err_q}) + $signed({eprod_q[33], eprod_q[33:16]});
    if (esum > 19'sd32767) begin
      esat = 16'sd32767;
    end else if (esum < -19'sd32768) begin
      esat = -16'sd32768;
    end else begin
      esat = esum[15:0];
    end
    err_new = task_q.mode ? esat : err_q;
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer: next state and pop
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    fire    = 1'b0;
    case (state_q)
      lspf_pkg::BK_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          state_d = lspf_pkg::BK_LEVEL;
        end
      end
      lspf_pkg::BK_LEVEL: state_d = lspf_pkg::BK_SUM;
      lspf_pkg::BK_SUM:   state_d = lspf_pkg::BK_DIV;
      lspf_pkg::BK_DIV:   state_d = lspf_pkg::BK_ERR;
      lspf_pkg::BK_ERR:   state_d = lspf_pkg::BK_FIN;
      lspf_pkg::BK_FIN: begin
        if (out_free) begin
          fire = 1'b1;
          if (head_i.valid) begin
            pop_o   = 1'b1;
            state_d = lspf_pkg::BK_LEVEL;
          end else begin
            state_d = lspf_pkg::BK_IDLE;
          end
        end
      end
      default: state_d = lspf_pkg::BK_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lspf_pkg::BK_IDLE;
      primed_q    <= 1'b0;
      lvl_q       <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lspf_pkg::BK_LEVEL) begin
        if (primed_q) begin
          lvl_q <= lvl_next;
        end else begin
          // first item loads the levels and clears the error
          lvl_q    <= lvl_tgt;
          err_q    <= '0;
          primed_q <= 1'b1;
        end
      end
      if (fire) begin
        err_q       <= err_new;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      task_q <= head_i.data;
    end
    if (state_q == lspf_pkg::BK_SUM) begin
      on_q  <= on_now;
      sum_q <= sum_now;
      cnt_q <= cnt_now;
    end
    if (state_q == lspf_pkg::BK_DIV) begin
      mag_q  <= mag_now;
      neg_q  <= sum_q[17];
      div3_q <= mag_now * lspf_pkg::DIV3_RECIP;
    end
    if (state_q == lspf_pkg::BK_ERR) begin
      eprod_q <= eprod_now;
    end
    if (fire) begin
      out_q.level_far_left   <= 17'(lvl_q[3]);
      out_q.level_near_left  <= 17'(lvl_q[2]);
      out_q.level_near_right <= 17'(lvl_q[1]);
      out_q.level_far_right  <= 17'(lvl_q[0]);
      out_q.on_line_bits     <= on_q;
      out_q.filtered_error   <= err_new;
      out_q.line_lost        <= (on_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q[0] <= LVL_ONE && lvl_q[1] <= LVL_ONE && lvl_q[2] <= LVL_ONE && lvl_q[3] <= LVL_ONE)
    else $error("level filter left its range");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lspf_pkg::BK_FIN && out_valid_q && !out_ready_i) |=>
      state_q == lspf_pkg::BK_FIN)
    else $error("result overwrote a pending output");

  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lspf_pkg::BK_DIV |-> cnt_q == 3'($countones(on_q)))
    else $error("on-line count disagrees with on bits");

endmodule

FILE: hdl/line_sensor_position_filter.sv
// ----------------------------------------------------------------------------
// line_sensor_position_filter
// Low-pass filters four line-sensor levels and forms a filtered weighted
// position error.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one sample of
//   the four sensor pins plus a mode bit. The front end classifies it and
//   puts it into a two-entry queue. Output channel (out_valid_o /
//   out_ready_i / out_item_o) returns one result per sample: the four
//   filtered levels, the thresholded bits, the error store and line_lost.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i only
//   while the block is idle; the user must keep to this, the block does not
//   enforce it. A sample goes from the queue through the back-end steps
//   level, sum, divide, error and final into the output register; the five
//   steps share one datapath, so the back end takes a new sample only once
//   the last one is through. Reset clears the levels, the error store and
//   the primed flag and sets the configuration registers to their defaults;
//   the first sample after reset loads the levels directly. When the receiver
//   stalls, the finished result is held in the output register, the back
//   end waits in its final step and the queue keeps taking input until full.
// ----------------------------------------------------------------------------
module line_sensor_position_filter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lspf_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lspf_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [lspf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [lspf_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  lspf_pkg::cfg_t        cfg_q;
  lspf_pkg::queue_head_t head;
  logic                  pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_high <= lspf_pkg::RST_ACTIVE_HIGH;
      cfg_q.level_alpha <= lspf_pkg::RST_ALPHA;
      cfg_q.error_alpha <= lspf_pkg::RST_ALPHA;
      cfg_q.weight[3]   <= lspf_pkg::RST_W_FAR_LEFT;
      cfg_q.weight[2]   <= lspf_pkg::RST_W_NEAR_LEFT;
      cfg_q.weight[1]   <= lspf_pkg::RST_W_NEAR_RIGHT;
      cfg_q.weight[0]   <= lspf_pkg::RST_W_FAR_RIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lspf_pkg::CFG_ACTIVE_HIGH:       cfg_q.active_high <= cfg_wdata_i[0];
        lspf_pkg::CFG_LEVEL_ALPHA:       cfg_q.level_alpha <= cfg_wdata_i;
        lspf_pkg::CFG_ERROR_ALPHA:       cfg_q.error_alpha <= cfg_wdata_i;
        lspf_pkg::CFG_WEIGHT_FAR_LEFT:   cfg_q.weight[3] <= cfg_wdata_i;
        lspf_pkg::CFG_WEIGHT_NEAR_LEFT:  cfg_q.weight[2] <= cfg_wdata_i;
        lspf_pkg::CFG_WEIGHT_NEAR_RIGHT: cfg_q.weight[1] <= cfg_wdata_i;
        lspf_pkg::CFG_WEIGHT_FAR_RIGHT:  cfg_q.weight[0] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lspf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .active_high_i (cfg_q.active_high),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .pop_i         (pop),
    .head_o        (head)
  );

  lspf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
